[rtl/brms_pkg.sv]
package brms_pkg;

  localparam int RAW_W      = 32;
  localparam int SHIFT      = 8;
  localparam int SAMPLE_W   = 24;
  localparam int SQ_W       = 47;
  localparam int SQ_SUM_W   = 46;
  localparam int MEAN_W     = 47;
  localparam int ROOT_W     = 24;
  localparam int SQRT_W     = 48;
  localparam int OUT_CNT_W  = 11;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_SQRT = 4'b0100,
    ST_OUT  = 4'b1000
  } back_state_e;

endpackage

[rtl/brms_front.sv]
module brms_front
  import brms_pkg::*;
#(
  parameter int MAX_COUNT = 1024,
  parameter int CW        = 11,
  parameter int SW        = 57
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic signed [RAW_W-1:0] raw_word_i,
  input  logic                   last_sample_i,
  output logic                   push_valid_o,
  input  logic                   push_ready_i,
  output logic [SW+CW:0]         push_data_o
);

  logic [SAMPLE_W-1:0] sample;
  logic [SAMPLE_W-1:0] mag;
  logic [2*SAMPLE_W-1:0] prod;

  logic          s1_valid_q, s1_valid_d;
  logic          s1_last_q;
  logic [SQ_W-1:0] s1_sq_q;
  logic          s1_adv;

  logic [SW-1:0] sum_q, sum_d, sum_nx;
  logic [CW-1:0] cnt_q, cnt_d, cnt_nx;
  logic          ovf_q, ovf_d, ovf_nx;

  assign sample = raw_word_i[RAW_W-1:SHIFT];
  assign mag    = sample[SAMPLE_W-1] ? (~sample + SAMPLE_W'(1)) : sample;
  assign prod   = mag * mag;

  assign s1_adv     = !(s1_last_q && !push_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign s1_valid_d = (in_valid_i && in_ready_o) || (s1_valid_q && !s1_adv);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_sq_q   <= prod[SQ_W-1:0];
      s1_last_q <= last_sample_i;
    end
  end

  always_comb begin
    sum_nx = sum_q;
    cnt_nx = cnt_q;
    ovf_nx = ovf_q;
    if (cnt_q < CW'(MAX_COUNT)) begin
      sum_nx = sum_q + SW'(s1_sq_q);
      cnt_nx = cnt_q + CW'(1);
    end else begin
      ovf_nx = 1'b1;
    end
    sum_d = sum_q;
    cnt_d = cnt_q;
    ovf_d = ovf_q;
    if (s1_valid_q && s1_adv) begin
      if (s1_last_q) begin
        sum_d = '0;
        cnt_d = '0;
        ovf_d = 1'b0;
      end else begin
        sum_d = sum_nx;
        cnt_d = cnt_nx;
        ovf_d = ovf_nx;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      cnt_q <= '0;
      ovf_q <= 1'b0;
    end else begin
      sum_q <= sum_d;
      cnt_q <= cnt_d;
      ovf_q <= ovf_d;
    end
  end

  assign push_valid_o = s1_valid_q && s1_last_q;
  assign push_data_o  = {ovf_nx, cnt_nx, sum_nx};

endmodule

[rtl/brms_queue.sv]
module brms_queue #(
  parameter int W = 69
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         wr_valid_i,
  output logic         wr_ready_o,
  input  logic [W-1:0] wr_data_i,
  output logic         rd_valid_o,
  input  logic         rd_ready_i,
  output logic [W-1:0] rd_data_o
);

  logic [W-1:0] mem [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] fill_q;
  logic       do_wr, do_rd;

  assign wr_ready_o = (fill_q != 2'd2);
  assign rd_valid_o = (fill_q != 2'd0);
  assign rd_data_o  = mem[rd_ptr_q];
  assign do_wr      = wr_valid_i && wr_ready_o;
  assign do_rd      = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (do_rd) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      case ({do_wr, do_rd})
        2'b10:   fill_q <= fill_q + 2'd1;
        2'b01:   fill_q <= fill_q - 2'd1;
        default: fill_q <= fill_q;
      endcase
    end
  end

endmodule

[rtl/brms_back.sv]
module brms_back
  import brms_pkg::*;
#(
  parameter int CW = 11,
  parameter int SW = 57
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 pop_valid_i,
  output logic                 pop_ready_o,
  input  logic [SW+CW:0]       pop_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [ROOT_W-1:0]    rms_value_o,
  output logic [OUT_CNT_W-1:0] sample_count_o,
  output logic                 too_many_o
);

  localparam int ITER_W = $clog2(SW + 1);

  back_state_e state_q, state_d;
  logic [ITER_W-1:0] iter_q, iter_d;
  logic [SW-1:0]     div_q, div_d;
  logic [CW:0]       rem_q, rem_d;
  logic [CW-1:0]     cnt_q;
  logic              ovf_q;
  logic [SQRT_W-1:0] v_q, v_d, root_q, root_d, bit_q, bit_d;

  logic [CW:0]       rem_sh;
  logic              ge;
  logic [SQRT_W-1:0] trial;
  logic [CW+OUT_CNT_W-1:0] cnt_ext;

  assign pop_ready_o = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);
  assign too_many_o  = ovf_q;
  assign cnt_ext     = {{OUT_CNT_W{1'b0}}, cnt_q};
  assign sample_count_o = cnt_ext[OUT_CNT_W-1:0];
  assign rms_value_o = root_q[ROOT_W-1:0];

  assign rem_sh = {rem_q[CW-1:0], div_q[SW-1]};
  assign ge     = (rem_sh >= {1'b0, cnt_q});
  assign trial  = root_q + bit_q;

  always_comb begin
    state_d = state_q;
    iter_d  = iter_q;
    div_d   = div_q;
    rem_d   = rem_q;
    v_d     = v_q;
    root_d  = root_q;
    bit_d   = bit_q;
    case (state_q)
      ST_IDLE: begin
        if (pop_valid_i) begin
          state_d = ST_DIV;
          iter_d  = ITER_W'(SW - 1);
          div_d   = pop_data_i[SW-1:0];
          rem_d   = '0;
        end
      end
      ST_DIV: begin
        rem_d = ge ? (rem_sh - {1'b0, cnt_q}) : rem_sh;
        div_d = {div_q[SW-2:0], ge};
        if (iter_q == '0) begin
          state_d = ST_SQRT;
          iter_d  = ITER_W'(ROOT_W - 1);
          v_d     = SQRT_W'(div_d[MEAN_W-1:0]);
          root_d  = '0;
          bit_d   = SQRT_W'(1) << (2 * (ROOT_W - 1));
        end else begin
          iter_d = iter_q - ITER_W'(1);
        end
      end
      ST_SQRT: begin
        if (v_q >= trial) begin
          v_d    = v_q - trial;
          root_d = (root_q >> 1) + bit_q;
        end else begin
          root_d = root_q >> 1;
        end
        bit_d = bit_q >> 2;
        if (iter_q == '0) begin
          state_d = ST_OUT;
        end else begin
          iter_d = iter_q - ITER_W'(1);
        end
      end
      ST_OUT: begin
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    iter_q <= iter_d;
    div_q  <= div_d;
    rem_q  <= rem_d;
    v_q    <= v_d;
    root_q <= root_d;
    bit_q  <= bit_d;
    if (state_q == ST_IDLE && pop_valid_i) begin
      cnt_q <= pop_data_i[SW+CW-1:SW];
      ovf_q <= pop_data_i[SW+CW];
    end
  end

endmodule

[rtl/block_rms_level.sv]
// Channel | Handshake             | Payload
// --------+-----------------------+-----------------------------------------
// in      | in_valid_i/in_ready_o | raw_word_i[31:0], last_sample_i
// out     | out_valid_o/out_ready_i | rms_value_o[23:0], sample_count_o[10:0],
//         |                       | too_many_o
//
// One item per cycle into the square-and-accumulate front; a sample's square
// is registered in s1 before it is added to the running sum.
// Per block the back end runs restoring division (one quotient bit a cycle),
// then a bitwise square root, then holds the result until taken, and takes
// the next block only when idle; SW = 46 + clog2(MAX_COUNT + 1).
// A two-entry queue holds closed blocks; the front stalls only when a block
// closes with the queue full. Reset clears the front's sums and counts and all valids.
module block_rms_level
  import brms_pkg::*;
#(
  parameter int MAX_COUNT = 1024
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic signed [RAW_W-1:0] raw_word_i,
  input  logic                    last_sample_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [ROOT_W-1:0]       rms_value_o,
  output logic [OUT_CNT_W-1:0]    sample_count_o,
  output logic                    too_many_o
);

  localparam int CW = $clog2(MAX_COUNT + 1);
  localparam int SW = SQ_SUM_W + CW;

  logic          push_valid, push_ready;
  logic [SW+CW:0] push_data;
  logic          pop_valid, pop_ready;
  logic [SW+CW:0] pop_data;

  brms_front #(
    .MAX_COUNT(MAX_COUNT),
    .CW       (CW),
    .SW       (SW)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .raw_word_i   (raw_word_i),
    .last_sample_i(last_sample_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  brms_queue #(
    .W(SW + CW + 1)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_valid_i(push_valid),
    .wr_ready_o(push_ready),
    .wr_data_i (push_data),
    .rd_valid_o(pop_valid),
    .rd_ready_i(pop_ready),
    .rd_data_o (pop_data)
  );

  brms_back #(
    .CW(CW),
    .SW(SW)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pop_valid_i   (pop_valid),
    .pop_ready_o   (pop_ready),
    .pop_data_i    (pop_data),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .rms_value_o   (rms_value_o),
    .sample_count_o(sample_count_o),
    .too_many_o    (too_many_o)
  );

endmodule

[tb/block_rms_level_chk.sv]
module block_rms_level_chk
  import brms_pkg::*;
#(
  parameter int MAX_COUNT = 1024
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic [RAW_W-1:0]     raw_word_i,
  input  logic                 last_sample_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic [ROOT_W-1:0]    rms_value_i,
  input  logic [OUT_CNT_W-1:0] sample_count_i,
  input  logic                 too_many_i,
  output int                   fail_count_o,
  output int                   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [ROOT_W-1:0]    rms;
    logic [OUT_CNT_W-1:0] count;
    logic                 over;
  } level_t;

  level_t      level_q[$];
  logic [63:0] sq_acc;
  int          n_acc;
  logic        over_acc;
  int          errs;
  int          pend;

  assign fail_count_o = errs;
  assign pending_o    = pend;

  function automatic logic [ROOT_W-1:0] floor_root(input logic [63:0] v);
    logic [ROOT_W-1:0] r;
    logic [ROOT_W-1:0] t;
    r = '0;
    for (int b = ROOT_W - 1; b >= 0; b--) begin
      t = r | (ROOT_W'(1) << b);
      if (64'(t) * 64'(t) <= v) r = t;
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    level_t                     want;
    level_t                     got;
    logic signed [SAMPLE_W-1:0] smp;
    longint                     mag;
    if (!rst_ni) begin
      level_q.delete();
      sq_acc   = '0;
      n_acc    = 0;
      over_acc = 1'b0;
      errs     = 0;
      pend     = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        got = '{rms: rms_value_i, count: sample_count_i, over: too_many_i};
        if (level_q.size() == 0) begin
          errs++;
          $display("%0t: unexpected result rms=%0d count=%0d too_many=%0b",
                   $time, got.rms, got.count, got.over);
        end else begin
          want = level_q.pop_front();
          if (got !== want) begin
            errs++;
            $display({"%0t: expected rms=%0d count=%0d too_many=%0b,",
                      " actual rms=%0d count=%0d too_many=%0b"},
                     $time, want.rms, want.count, want.over,
                     got.rms, got.count, got.over);
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        smp = raw_word_i[RAW_W-1:SHIFT];
        mag = longint'(smp);
        if (mag < 0) mag = -mag;
        if (n_acc < MAX_COUNT) begin
          sq_acc = sq_acc + 64'(mag * mag);
          n_acc++;
        end else begin
          over_acc = 1'b1;
        end
        if (last_sample_i) begin
          want.rms   = floor_root(sq_acc / 64'(n_acc));
          want.count = OUT_CNT_W'(n_acc);
          want.over  = over_acc;
          level_q.push_back(want);
          sq_acc   = '0;
          n_acc    = 0;
          over_acc = 1'b0;
        end
      end
      pend = level_q.size();
    end
  end

endmodule

[tb/block_rms_level_tb.sv]
module block_rms_level_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import brms_pkg::*;

  localparam int MAX_COUNT   = 1024;
  localparam int HOLD_CYCLES = 600;
  localparam int DRAIN       = 150;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_ready_o;
  logic signed [RAW_W-1:0] raw_word_i;
  logic                    last_sample_i;
  logic                    out_valid_o;
  logic                    out_ready_i;
  logic [ROOT_W-1:0]       rms_value_o;
  logic [OUT_CNT_W-1:0]    sample_count_o;
  logic                    too_many_o;
  int                      fail_count;
  int                      pending;
  bit                      idle_on;
  bit                      hold_req;
  bit                      hold_done;

  block_rms_level #(.MAX_COUNT(MAX_COUNT)) dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .raw_word_i, .last_sample_i,
    .out_valid_o, .out_ready_i, .rms_value_o, .sample_count_o, .too_many_o
  );

  block_rms_level_chk #(.MAX_COUNT(MAX_COUNT)) chk (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .raw_word_i, .last_sample_i,
    .out_valid_i(out_valid_o), .out_ready_i, .rms_value_i(rms_value_o),
    .sample_count_i(sample_count_o), .too_many_i(too_many_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  initial begin
    #5_000_000;
    $display("block_rms_level_tb: errors");
    $finish;
  end

  // receiver: random stalls, one long hold on request
  initial begin
    int burst;
    burst = 0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_done) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_done = 1'b1;
        out_ready_i <= 1'b1;
      end else if (burst > 0) begin
        burst--;
        out_ready_i <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        burst = $urandom_range(0, 11);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  function automatic logic [RAW_W-1:0] pick_word();
    logic [RAW_W-1:0] w;
    w = $urandom;
    case ($urandom_range(0, 9))
      0: w = {1'b1, 23'd0, w[7:0]};
      1: w = {1'b0, {23{1'b1}}, w[7:0]};
      2: w = {{20{w[31]}}, w[11:0]};
      default: ;
    endcase
    return w;
  endfunction

  task automatic put_item(input logic [RAW_W-1:0] word, input logic last);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    raw_word_i    <= word;
    last_sample_i <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_block(input int len);
    for (int i = 0; i < len; i++) put_item(pick_word(), i == len - 1);
  endtask

  task automatic wait_drained();
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN) @(negedge clk_i);
  endtask

  initial begin
    int sent;
    int len;
    int r;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    raw_word_i    = '0;
    last_sample_i = 1'b0;
    idle_on       = 1'b1;
    hold_req      = 1'b0;
    hold_done     = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // extremes, low bits ignored, short blocks
    put_item(32'h7FFF_FF00, 1'b1);
    put_item(32'h8000_0000, 1'b1);
    put_item(32'h0000_00FF, 1'b1);
    put_item(32'hFFFF_FFFF, 1'b1);
    put_item(32'h0000_0100, 1'b1);
    put_item(32'hFFFF_FF00, 1'b0);
    put_item(32'h0000_0100, 1'b1);
    put_item(32'h8000_00AA, 1'b0);
    put_item(32'h7FFF_FF55, 1'b0);
    put_item(32'h8000_0000, 1'b0);
    put_item(32'h7FFF_FFFF, 1'b1);
    put_item(32'h1234_5678, 1'b0);
    put_item(32'h8765_4321, 1'b0);
    put_item(32'hA5A5_A5A5, 1'b1);
    put_item(32'h5A5A_5A5A, 1'b1);
    put_item(32'h0000_0000, 1'b1);
    put_item(32'hFFFF_FE00, 1'b0);
    put_item(32'h0000_0300, 1'b1);

    // overflow block of the most negative sample, closing sample past full
    for (int i = 0; i < MAX_COUNT + 3; i++) put_item(32'h8000_0000, i == MAX_COUNT + 2);

    // hold the receiver while offering short blocks
    hold_req = 1'b1;
    for (int i = 0; i < 40; i++) send_block($urandom_range(1, 2));
    in_valid_i <= 1'b0;
    while (!hold_done) @(negedge clk_i);

    // pause until all results are out
    wait_drained();

    sent = 0;
    while (sent < 100) begin
      r = $urandom_range(0, 19);
      if (r < 16) len = $urandom_range(1, 16);
      else if (r < 19) len = $urandom_range(17, 60);
      else len = $urandom_range(61, 120);
      idle_on = ($urandom_range(0, 3) != 0);
      send_block(len);
      sent += len;
    end

    idle_on = 1'b0;
    sent = 0;
    while (sent < 40) begin
      len = $urandom_range(1, 8);
      send_block(len);
      sent += len;
    end

    in_valid_i <= 1'b0;
    wait_drained();
    if (fail_count == 0) $display("block_rms_level_tb: clean");
    else $display("block_rms_level_tb: errors");
    $finish;
  end

endmodule
